// File: rtl/core/quantized_pixel_rle_encoder_unit_macros.svh
// assertion macros shared by the quantized pixel rle encoder rtl
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef QUANTIZED_PIXEL_RLE_ENCODER_UNIT_MACROS_SVH
`define QUANTIZED_PIXEL_RLE_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define QPRLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define QPRLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles, off while in reset
`define QPRLE_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// File: rtl/core/qprle_pkg.sv
// shared types and constants of the quantized pixel rle encoder
// no dependencies; every other rtl module and interface imports this package
package qprle_pkg;

  localparam int CHAN_W          = 8;   // bits per channel and per run count
  localparam int NUM_CHAN        = 4;   // channel fields carried on the ports
  localparam int ACT_W           = 3;   // width of the active channel register
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;
  localparam int MAX_CHANNELS_DEF = 4;
  localparam int OQ_DEPTH_DEF    = 4;   // result queue entries, at least 2

  localparam logic [CHAN_W-1:0] COUNT_LIMIT = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CH  = 2'd1;

  localparam logic [CHAN_W-1:0] QUANT_STEP_RST = 8'd1;
  localparam logic [ACT_W-1:0]  ACTIVE_CH_RST  = 3'd4;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_arr_t;

  typedef struct packed {
    logic [CHAN_W-1:0] count;
    chan_arr_t         chan;
    logic              last;
  } rec_t;

  typedef struct packed {
    logic load;   // capture raw value, step and active flag
    logic step;   // one remainder iteration
  } lane_ctl_t;

  typedef struct packed {
    logic en;     // quantized pixel is ready, update the run
    logic eof;    // flush after this pixel
  } merge_ctl_t;

  typedef struct packed {
    logic [1:0] n;     // records pushed this cycle, 0..2
    rec_t       rec0;  // first record in order
    rec_t       rec1;  // second record, valid when n is 2
  } push_t;

endpackage

// File: rtl/core/qprle_pix_if.sv
// pixel request channel: valid/ready plus the raw channel fields
// depends on qprle_pkg
interface qprle_pix_if import qprle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan0_in;
  logic [CHAN_W-1:0] chan1_in;
  logic [CHAN_W-1:0] chan2_in;
  logic [CHAN_W-1:0] chan3_in;
  logic              end_of_frame;

  modport source (output valid, chan0_in, chan1_in, chan2_in, chan3_in, end_of_frame,
                  input ready);
  modport sink   (input valid, chan0_in, chan1_in, chan2_in, chan3_in, end_of_frame,
                  output ready);
endinterface

// File: rtl/core/qprle_rec_if.sv
// run record channel: valid/ready plus the record fields
// depends on qprle_pkg
interface qprle_rec_if import qprle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] run_count;
  logic [CHAN_W-1:0] run_chan0;
  logic [CHAN_W-1:0] run_chan1;
  logic [CHAN_W-1:0] run_chan2;
  logic [CHAN_W-1:0] run_chan3;
  logic              last_record;

  modport source (output valid, run_count, run_chan0, run_chan1, run_chan2, run_chan3,
                  last_record, input ready);
  modport sink   (input valid, run_count, run_chan0, run_chan1, run_chan2, run_chan3,
                  last_record, output ready);
endinterface

// File: rtl/core/qprle_cfg_if.sv
// configuration write channel: valid/ready, register index and data
// depends on qprle_pkg
interface qprle_cfg_if import qprle_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/core/quantized_pixel_rle_encoder_unit.sv
// top level of the quantized pixel run-length encoder
// depends on qprle_pkg, the three channel interfaces, qprle_lane, qprle_merge, qprle_outq
// and the assertion macro header
//
// Takes one pixel of up to four 8-bit channels per request, rounds each active
// channel down to a multiple of quant_step and extends or closes the current run.
// A closed run and, on end_of_frame, the flushed final run (last_record set) come
// out as records of run count plus quantized channels, inactive channels as zero;
// a pixel gives zero, one or two records, in that order. Each pixel is taken in,
// then runs through restoring remainder in the channel lanes (one quotient bit per
// cycle, all lanes in parallel), then the run tracker merges the lanes and queues
// the records; the next pixel is accepted only once the merge is done. Records
// wait in a small queue, so pixels keep flowing while the result side stalls, as
// long as the queue has room for two records. A quant_step of 0 acts as 1;
// active_channels of 0 acts as 1 and values above MAX_CHANNELS saturate.
// Configuration must be written by the user only while no pixel is in flight; the block does not enforce it.
`include "quantized_pixel_rle_encoder_unit_macros.svh"

module quantized_pixel_rle_encoder_unit import qprle_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int OQ_DEPTH     = OQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  qprle_pix_if.sink   in_ch,
  qprle_rec_if.source out_ch,
  qprle_cfg_if.sink   cfg_ch
);

  localparam int ITER_W = $clog2(CHAN_W);
  localparam int LAT    = CHAN_W + 1;   // accept edge to merge edge

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CALC  = 3'b010,
    ST_MERGE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              eof_r, eof_nxt;
  logic [CHAN_W-1:0] quant_step_r, quant_step_nxt;
  logic [ACT_W-1:0]  active_ch_r, active_ch_nxt;

  logic [CHAN_W-1:0] step_eff;
  logic [ACT_W-1:0]  act_min1;
  logic [ACT_W-1:0]  act_eff;
  logic              in_req;
  logic              room2;
  logic              head_valid;
  rec_t              head;
  chan_arr_t         raw;
  chan_arr_t         q;
  lane_ctl_t         lane_ctl;
  merge_ctl_t        merge_ctl;
  push_t             push;

  // configuration registers, always ready
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    quant_step_nxt = quant_step_r;
    active_ch_nxt  = active_ch_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_QUANT_STEP: quant_step_nxt = cfg_ch.data;
        CFG_ACTIVE_CH:  active_ch_nxt  = cfg_ch.data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective step and channel count after the special cases
  assign step_eff = (quant_step_r == '0) ? CHAN_W'(1) : quant_step_r;
  assign act_min1 = (active_ch_r == '0) ? ACT_W'(1) : active_ch_r;
  assign act_eff  = (act_min1 > ACT_W'(MAX_CHANNELS)) ? ACT_W'(MAX_CHANNELS) : act_min1;

  // one pixel at a time; need room for a closed run plus a flush
  assign in_ch.ready = (state_r == ST_IDLE) && room2;
  assign in_req      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    eof_nxt   = eof_r;
    lane_ctl  = '0;
    merge_ctl = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          lane_ctl.load = 1'b1;
          eof_nxt       = in_ch.end_of_frame;
          iter_nxt      = '0;
          state_nxt     = ST_CALC;
        end
      end
      ST_CALC: begin
        lane_ctl.step = 1'b1;
        iter_nxt      = iter_r + 1'b1;
        if (iter_r == ITER_W'(CHAN_W - 1)) state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        merge_ctl.en  = 1'b1;
        merge_ctl.eof = eof_r;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      iter_r       <= '0;
      eof_r        <= 1'b0;
      quant_step_r <= QUANT_STEP_RST;
      active_ch_r  <= ACTIVE_CH_RST;
    end else begin
      state_r      <= state_nxt;
      iter_r       <= iter_nxt;
      eof_r        <= eof_nxt;
      quant_step_r <= quant_step_nxt;
      active_ch_r  <= active_ch_nxt;
    end
  end

  assign raw[0] = in_ch.chan0_in;
  assign raw[1] = in_ch.chan1_in;
  assign raw[2] = in_ch.chan2_in;
  assign raw[3] = in_ch.chan3_in;

  // channel lanes; channels past MAX_CHANNELS are always zero
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    if (c < MAX_CHANNELS) begin : g_on
      qprle_lane u_lane (
        .clk     (clk),
        .ctl     (lane_ctl),
        .v_in    (raw[c]),
        .step_in (step_eff),
        .act_in  (ACT_W'(c) < act_eff),
        .q_out   (q[c])
      );
    end else begin : g_off
      assign q[c] = '0;
    end
  end

  // run tracker merges the lanes
  qprle_merge #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (merge_ctl),
    .q_in  (q),
    .push  (push)
  );

  // record queue decouples the result side
  qprle_outq #(
    .DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_ch.valid && out_ch.ready),
    .head       (head),
    .head_valid (head_valid),
    .room2      (room2)
  );

  assign out_ch.valid       = head_valid;
  assign out_ch.run_count   = head.count;
  assign out_ch.run_chan0   = head.chan[0];
  assign out_ch.run_chan1   = head.chan[1];
  assign out_ch.run_chan2   = head.chan[2];
  assign out_ch.run_chan3   = head.chan[3];
  assign out_ch.last_record = head.last;

  // queue space reserved at accept must still be there at merge
  `QPRLE_ASSERT_IMP(a_merge_room, state_r == ST_MERGE, room2, "record queue overflow")
  // a pixel reaches the merge a fixed number of cycles after acceptance
  `QPRLE_ASSERT_DLY(a_merge_lat, in_req, LAT, state_r == ST_MERGE, "merge latency broken")
  // merge lasts exactly one cycle
  `QPRLE_ASSERT_NXT(a_merge_once, state_r == ST_MERGE, state_r == ST_IDLE, "merge repeated")
  // records are pushed only during merge
  `QPRLE_ASSERT_IMP(a_push_merge, state_r != ST_MERGE, push.n == 2'd0, "stray record push")

endmodule

// File: rtl/core/qprle_lane.sv
// one channel lane: quantizes v down to a multiple of step
// restoring remainder, one bit per cycle; depends on qprle_pkg
module qprle_lane import qprle_pkg::*; (
  input  logic              clk,
  input  lane_ctl_t         ctl,
  input  logic [CHAN_W-1:0] v_in,
  input  logic [CHAN_W-1:0] step_in,
  input  logic              act_in,
  output logic [CHAN_W-1:0] q_out
);

  logic [CHAN_W-1:0] orig_r, orig_nxt;
  logic [CHAN_W-1:0] shf_r, shf_nxt;
  logic [CHAN_W-1:0] rem_r, rem_nxt;
  logic [CHAN_W-1:0] step_r, step_nxt;
  logic              act_r, act_nxt;
  logic [CHAN_W:0]   cand;

  always_comb begin
    orig_nxt = orig_r;
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    act_nxt  = act_r;
    cand     = {rem_r, shf_r[CHAN_W-1]};
    if (ctl.load) begin
      orig_nxt = v_in;
      shf_nxt  = v_in;
      rem_nxt  = '0;
      step_nxt = step_in;
      act_nxt  = act_in;
    end else if (ctl.step) begin
      shf_nxt = {shf_r[CHAN_W-2:0], 1'b0};
      if (cand >= {1'b0, step_r}) begin
        rem_nxt = CHAN_W'(cand - {1'b0, step_r});
      end else begin
        rem_nxt = cand[CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    orig_r <= orig_nxt;
    shf_r  <= shf_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    act_r  <= act_nxt;
  end

  // valid once all bits have been shifted through
  assign q_out = act_r ? (orig_r - rem_r) : '0;

endmodule

// File: rtl/core/qprle_merge.sv
// run tracker: compares the lanes with the held run and builds records
// depends on qprle_pkg
module qprle_merge import qprle_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  merge_ctl_t ctl,
  input  chan_arr_t  q_in,
  output push_t      push
);

  logic [MAX_CHANNELS-1:0][CHAN_W-1:0] held_r, held_nxt;
  logic [CHAN_W-1:0]                   count_r, count_nxt;
  logic                                open_r, open_nxt;

  chan_arr_t         held_full;
  chan_arr_t         mid_full;
  logic              same;
  logic              extend;
  logic              close_emit;
  logic [CHAN_W-1:0] mid_count;
  rec_t              rec_close;
  rec_t              rec_flush;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_full
    if (c < MAX_CHANNELS) begin : g_held
      assign held_full[c] = held_r[c];
    end else begin : g_zero
      assign held_full[c] = '0;
    end
  end

  always_comb begin
    same = 1'b1;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (q_in[c] != held_full[c]) same = 1'b0;
    end
    extend     = open_r && same && (count_r != COUNT_LIMIT);
    close_emit = open_r && !extend;
    mid_full   = extend ? held_full : q_in;
    mid_count  = extend ? count_r + 1'b1 : CHAN_W'(1);

    rec_close.count = count_r;
    rec_close.chan  = held_full;
    rec_close.last  = 1'b0;
    rec_flush.count = mid_count;
    rec_flush.chan  = mid_full;
    rec_flush.last  = 1'b1;

    push.n    = ctl.en ? (2'(close_emit) + 2'(ctl.eof)) : 2'd0;
    push.rec0 = close_emit ? rec_close : rec_flush;
    push.rec1 = rec_flush;

    held_nxt  = held_r;
    count_nxt = count_r;
    open_nxt  = open_r;
    if (ctl.en) begin
      if (ctl.eof) begin
        held_nxt  = '0;
        count_nxt = '0;
        open_nxt  = 1'b0;
      end else begin
        for (int c = 0; c < MAX_CHANNELS; c++) held_nxt[c] = mid_full[c];
        count_nxt = mid_count;
        open_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      count_r <= '0;
      open_r  <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      count_r <= count_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

// File: rtl/core/qprle_outq.sv
// small record queue, takes up to two records a cycle, gives one
// depends on qprle_pkg
module qprle_outq import qprle_pkg::*; #(
  parameter int DEPTH = OQ_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output rec_t  head,
  output logic  head_valid,
  output logic  room2
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_p1;

  function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign wr_p1 = inc_ptr(wr_r);

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (push.n == 2'd1) wr_nxt = wr_p1;
    else if (push.n == 2'd2) wr_nxt = inc_ptr(wr_p1);
    if (pop) rd_nxt = inc_ptr(rd_r);
    cnt_nxt = cnt_r + CNT_W'(push.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_r] <= push.rec0;
    if (push.n == 2'd2) mem_r[wr_p1] <= push.rec1;
  end

  assign head       = mem_r[rd_r];
  assign head_valid = (cnt_r != '0);
  assign room2      = (cnt_r <= CNT_W'(DEPTH - 2));

endmodule
